// File: rtl/h2r_pkg.sv
// Shared constants, types and fixed-point formats of the HSV to RGB converter.
package h2r_pkg;

  // Hue format: degrees with HUE_FRAC_BITS fractional bits
  localparam int HUE_FRAC_BITS = 7;
  localparam int HUE_W         = 16;
  localparam int PIX_W         = 8;
  localparam int PROD_W        = 2 * PIX_W;

  // Hue units in one sextant (60 degrees) and in a full circle
  localparam longint unsigned SEXT_UNITS   = 64'd60 << HUE_FRAC_BITS;
  localparam longint unsigned CIRCLE_UNITS = SEXT_UNITS * 64'd6;
  localparam logic [31:0]     SEXT_32      = 32'(SEXT_UNITS);
  localparam logic [31:0]     CIRCLE_32    = 32'(CIRCLE_UNITS);

  // Sextant weight t spans 0 .. SEXT_UNITS inclusive
  localparam int T_W = $clog2(SEXT_UNITS + 64'd1);

  // SEXT_UNITS = 15 << SEXT_SHIFT, so dividing by it is a shift and a divide by 15
  localparam int SEXT_SHIFT = HUE_FRAC_BITS + 2;
  localparam int DIV_A      = 15;
  localparam int FULL_SCALE = 255;

  // Numerator of the x+m channel: at most 255*255*SEXT_UNITS
  localparam int NUM_W = $clog2(64'd65025 * SEXT_UNITS + 64'd1);

  // Numerator after the shift is at most 255*255*15, quotient by 15 at most 255*255
  localparam int Q15_W = 20;
  localparam int Q255_W = PROD_W;

  // Reciprocal estimates; each one is low by at most one, fixed by a single compare
  localparam int               RCP15_SH  = Q15_W;
  localparam int               RCP15_W   = 17;
  localparam logic [RCP15_W-1:0] RCP15   = RCP15_W'((64'd1 << RCP15_SH) / 64'd15);
  localparam int               RCP255_SH = Q255_W;
  localparam int               RCP255_W  = 9;
  localparam logic [RCP255_W-1:0] RCP255 = RCP255_W'((64'd1 << RCP255_SH) / 64'd255);

  // Hue sextants, named after the colors at their ends
  typedef enum logic [2:0] {
    SEXT_RED_YEL = 3'd0,
    SEXT_YEL_GRN = 3'd1,
    SEXT_GRN_CYN = 3'd2,
    SEXT_CYN_BLU = 3'd3,
    SEXT_BLU_MAG = 3'd4,
    SEXT_MAG_RED = 3'd5
  } sextant_t;

  // Front end result: sextant, weight and the two chroma products
  typedef struct packed {
    sextant_t             k;
    logic [T_W-1:0]       t;
    logic [PROD_W-1:0]    vs;
    logic [PROD_W-1:0]    p;
    logic [PIX_W-1:0]     v;
  } h2r_wt_t;

  // Mixer result: shifted x numerator, offset channel and brightness
  typedef struct packed {
    sextant_t             k;
    logic [Q15_W-1:0]     q1;
    logic [PIX_W-1:0]     m;
    logic [PIX_W-1:0]     v;
  } h2r_mx_t;

endpackage

// File: rtl/h2r_front.sv
// Hue wrap, sextant search, sextant weight and chroma products (two stages).
module h2r_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         vld_in,
  input  logic [h2r_pkg::HUE_W-1:0]    hue,
  input  logic [h2r_pkg::PIX_W-1:0]    sat,
  input  logic [h2r_pkg::PIX_W-1:0]    bri,
  output logic                         vld_out,
  output h2r_pkg::h2r_wt_t             wt_out
);
  import h2r_pkg::*;

  logic              vld_a_r;
  logic [HUE_W-1:0]  h_r;
  logic [PIX_W-1:0]  s_r;
  logic [PIX_W-1:0]  v_r;
  logic [HUE_W-1:0]  h_nxt;
  logic [31:0]       hue_ext;
  logic [31:0]       hue_wrap;

  logic              vld_b_r;
  h2r_wt_t           wt_r;
  h2r_wt_t           wt_nxt;
  logic [2:0]        cnt;
  logic [31:0]       r_wide;
  logic [T_W-1:0]    r;

  // Wrap the hue once around the circle
  always_comb begin
    hue_ext  = {16'b0, hue};
    hue_wrap = (hue_ext >= CIRCLE_32) ? (hue_ext - CIRCLE_32) : hue_ext;
    h_nxt    = hue_wrap[HUE_W-1:0];
  end

  // Stage A valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= vld_in;
    end
  end

  // Stage A payload
  always_ff @(posedge clk) begin
    if (en) begin
      h_r <= h_nxt;
      s_r <= sat;
      v_r <= bri;
    end
  end

  // Count sextant boundaries at or below the hue
  always_comb begin
    cnt = 3'd0;
    for (int i = 1; i < 6; i++) begin
      if ({16'b0, h_r} >= SEXT_32 * 32'(i)) cnt = cnt + 3'd1;
    end
  end

  // Position inside the sextant, mirrored in odd sextants; chroma products
  always_comb begin
    r_wide    = {16'b0, h_r} - SEXT_32 * {29'b0, cnt};
    r         = r_wide[T_W-1:0];
    wt_nxt.k  = sextant_t'(cnt);
    wt_nxt.t  = cnt[0] ? (T_W'(SEXT_32) - r) : r;
    wt_nxt.vs = PROD_W'(v_r) * PROD_W'(s_r);
    wt_nxt.p  = PROD_W'(v_r) * PROD_W'(PIX_W'(FULL_SCALE) - s_r);
    wt_nxt.v  = v_r;
  end

  // Stage B valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else if (en) begin
      vld_b_r <= vld_a_r;
    end
  end

  // Stage B payload
  always_ff @(posedge clk) begin
    if (en) begin
      wt_r <= wt_nxt;
    end
  end

  assign vld_out = vld_b_r;
  assign wt_out  = wt_r;

endmodule

// File: rtl/h2r_mix.sv
// Weighted chroma sum for x+m and the offset channel m = v*(255-s)/255 (two stages).
module h2r_mix (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_in,
  input  h2r_pkg::h2r_wt_t  wt_in,
  output logic              vld_out,
  output h2r_pkg::h2r_mx_t  mx_out
);
  import h2r_pkg::*;

  logic                         vld_c_r;
  logic [NUM_W-1:0]             a_r;
  logic [NUM_W-1:0]             b_r;
  logic [PIX_W-1:0]             qm0_r;
  logic [PROD_W-1:0]            p_r;
  sextant_t                     k_r;
  logic [PIX_W-1:0]             v_r;
  logic [NUM_W-1:0]             a_nxt;
  logic [NUM_W-1:0]             b_nxt;
  logic [PROD_W+RCP255_W-1:0]   pm_prod;
  logic [PIX_W-1:0]             qm0_nxt;

  logic                         vld_d_r;
  h2r_mx_t                      mx_r;
  h2r_mx_t                      mx_nxt;
  logic [NUM_W-1:0]             num;
  logic [PROD_W-1:0]            rem_m;

  // Products: v*s*t, v*(255-s)*S, and the reciprocal estimate of m
  always_comb begin
    a_nxt   = NUM_W'(wt_in.vs) * NUM_W'(wt_in.t);
    b_nxt   = (NUM_W'(wt_in.p) * NUM_W'(DIV_A)) << SEXT_SHIFT;
    pm_prod = (PROD_W + RCP255_W)'(wt_in.p) * (PROD_W + RCP255_W)'(RCP255);
    qm0_nxt = PIX_W'(pm_prod >> RCP255_SH);
  end

  // Stage C valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
    end else if (en) begin
      vld_c_r <= vld_in;
    end
  end

  // Stage C payload
  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      qm0_r <= qm0_nxt;
      p_r   <= wt_in.p;
      k_r   <= wt_in.k;
      v_r   <= wt_in.v;
    end
  end

  // Sum numerator, drop the power-of-two part of S, correct the m estimate
  always_comb begin
    num       = a_r + b_r;
    rem_m     = p_r - PROD_W'(qm0_r) * PROD_W'(FULL_SCALE);
    mx_nxt.k  = k_r;
    mx_nxt.q1 = Q15_W'(num >> SEXT_SHIFT);
    mx_nxt.m  = (rem_m >= PROD_W'(FULL_SCALE)) ? (qm0_r + 8'd1) : qm0_r;
    mx_nxt.v  = v_r;
  end

  // Stage D valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d_r <= 1'b0;
    end else if (en) begin
      vld_d_r <= vld_c_r;
    end
  end

  // Stage D payload
  always_ff @(posedge clk) begin
    if (en) begin
      mx_r <= mx_nxt;
    end
  end

  assign vld_out = vld_d_r;
  assign mx_out  = mx_r;

endmodule

// File: rtl/h2r_scale.sv
// Divide the x numerator by 15 then by 255, and route channels by sextant (four stages).
module h2r_scale (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        vld_in,
  input  h2r_pkg::h2r_mx_t            mx_in,
  output logic                        vld_out,
  output logic [h2r_pkg::PIX_W-1:0]   red,
  output logic [h2r_pkg::PIX_W-1:0]   green,
  output logic [h2r_pkg::PIX_W-1:0]   blue
);
  import h2r_pkg::*;

  typedef struct packed {
    sextant_t          k;
    logic [PIX_W-1:0]  m;
    logic [PIX_W-1:0]  v;
  } side_t;

  // Stage E: estimate q1/15
  logic                         vld_e_r;
  logic [Q15_W-1:0]             q1_e_r;
  logic [Q255_W-1:0]            qa0_r;
  side_t                        sd_e_r;
  logic [Q15_W+RCP15_W-1:0]     qa_prod;
  logic [Q255_W-1:0]            qa0_nxt;

  // Stage F: corrected y = q1/15
  logic                         vld_f_r;
  logic [Q255_W-1:0]            y_f_r;
  side_t                        sd_f_r;
  logic [Q15_W-1:0]             rem_a;
  logic [Q255_W-1:0]            y_nxt;

  // Stage G: estimate y/255
  logic                         vld_g_r;
  logic [Q255_W-1:0]            y_g_r;
  logic [PIX_W-1:0]             qb0_r;
  side_t                        sd_g_r;
  logic [Q255_W+RCP255_W-1:0]   qb_prod;
  logic [PIX_W-1:0]             qb0_nxt;

  // Stage H: output register
  logic                         vld_h_r;
  logic [PIX_W-1:0]             red_r;
  logic [PIX_W-1:0]             green_r;
  logic [PIX_W-1:0]             blue_r;
  logic [Q255_W-1:0]            rem_b;
  logic [PIX_W-1:0]             x;
  logic [PIX_W-1:0]             red_nxt;
  logic [PIX_W-1:0]             green_nxt;
  logic [PIX_W-1:0]             blue_nxt;

  // Advance all stage valids together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_e_r <= 1'b0;
      vld_f_r <= 1'b0;
      vld_g_r <= 1'b0;
      vld_h_r <= 1'b0;
    end else if (en) begin
      vld_e_r <= vld_in;
      vld_f_r <= vld_e_r;
      vld_g_r <= vld_f_r;
      vld_h_r <= vld_g_r;
    end
  end

  // Reciprocal estimate of q1/15
  always_comb begin
    qa_prod = (Q15_W + RCP15_W)'(mx_in.q1) * (Q15_W + RCP15_W)'(RCP15);
    qa0_nxt = Q255_W'(qa_prod >> RCP15_SH);
  end

  // Correct the /15 estimate by one compare
  always_comb begin
    rem_a = q1_e_r - Q15_W'(qa0_r) * Q15_W'(DIV_A);
    y_nxt = (rem_a >= Q15_W'(DIV_A)) ? (qa0_r + 16'd1) : qa0_r;
  end

  // Reciprocal estimate of y/255
  always_comb begin
    qb_prod = (Q255_W + RCP255_W)'(y_f_r) * (Q255_W + RCP255_W)'(RCP255);
    qb0_nxt = PIX_W'(qb_prod >> RCP255_SH);
  end

  // Correct the /255 estimate, then route C, X and M to the channels
  always_comb begin
    rem_b = y_g_r - Q255_W'(qb0_r) * Q255_W'(FULL_SCALE);
    x     = (rem_b >= Q255_W'(FULL_SCALE)) ? (qb0_r + 8'd1) : qb0_r;
    unique case (sd_g_r.k)
      SEXT_RED_YEL: begin
        red_nxt = sd_g_r.v; green_nxt = x;        blue_nxt = sd_g_r.m;
      end
      SEXT_YEL_GRN: begin
        red_nxt = x;        green_nxt = sd_g_r.v; blue_nxt = sd_g_r.m;
      end
      SEXT_GRN_CYN: begin
        red_nxt = sd_g_r.m; green_nxt = sd_g_r.v; blue_nxt = x;
      end
      SEXT_CYN_BLU: begin
        red_nxt = sd_g_r.m; green_nxt = x;        blue_nxt = sd_g_r.v;
      end
      SEXT_BLU_MAG: begin
        red_nxt = x;        green_nxt = sd_g_r.m; blue_nxt = sd_g_r.v;
      end
      default: begin
        red_nxt = sd_g_r.v; green_nxt = sd_g_r.m; blue_nxt = x;
      end
    endcase
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      q1_e_r   <= mx_in.q1;
      qa0_r    <= qa0_nxt;
      sd_e_r   <= '{k: mx_in.k, m: mx_in.m, v: mx_in.v};
      y_f_r    <= y_nxt;
      sd_f_r   <= sd_e_r;
      y_g_r    <= y_f_r;
      qb0_r    <= qb0_nxt;
      sd_g_r   <= sd_f_r;
      red_r    <= red_nxt;
      green_r  <= green_nxt;
      blue_r   <= blue_nxt;
    end
  end

  assign vld_out = vld_h_r;
  assign red     = red_r;
  assign green   = green_r;
  assign blue    = blue_r;

endmodule

// File: rtl/hsv_to_rgb_converter.sv
// Top level of the pipelined HSV to RGB pixel converter.
// Converts one pixel per clock: hue in degrees with HUE_FRAC_BITS fractional
// bits, saturation and brightness as 8-bit fractions, to truncated 8-bit RGB.
// The pipeline is eight register stages deep, and the last stage is the
// output register. A request passes through stages A to H in order, and its
// result shows on the outputs once it reaches the output register.
// Throughput is one request per cycle as long as out_ready stays
// high. When the output register holds a result that is not taken, every
// stage freezes together and in_ready drops in the same cycle; no request
// is lost or repeated. The block holds no state beyond the pipeline.
module hsv_to_rgb_converter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [h2r_pkg::HUE_W-1:0]    in_hue,
  input  logic [h2r_pkg::PIX_W-1:0]    in_saturation,
  input  logic [h2r_pkg::PIX_W-1:0]    in_brightness,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [h2r_pkg::PIX_W-1:0]    out_red,
  output logic [h2r_pkg::PIX_W-1:0]    out_green,
  output logic [h2r_pkg::PIX_W-1:0]    out_blue
);
  import h2r_pkg::*;

  logic     adv;
  logic     vld_wt;
  logic     vld_mx;
  h2r_wt_t  wt;
  h2r_mx_t  mx;

  // Advance the whole pipeline unless a result waits at the output
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  h2r_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .vld_in  (in_valid),
    .hue     (in_hue),
    .sat     (in_saturation),
    .bri     (in_brightness),
    .vld_out (vld_wt),
    .wt_out  (wt)
  );

  h2r_mix u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .vld_in  (vld_wt),
    .wt_in   (wt),
    .vld_out (vld_mx),
    .mx_out  (mx)
  );

  h2r_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .vld_in  (vld_mx),
    .mx_in   (mx),
    .vld_out (out_valid),
    .red     (out_red),
    .green   (out_green),
    .blue    (out_blue)
  );

endmodule

// File: rtl/h2r_checker.sv
// Port-level checks of the HSV to RGB converter and their binding to the top level.
module h2r_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [h2r_pkg::HUE_W-1:0]    in_hue,
  input logic [h2r_pkg::PIX_W-1:0]    in_saturation,
  input logic [h2r_pkg::PIX_W-1:0]    in_brightness,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [h2r_pkg::PIX_W-1:0]    out_red,
  input logic [h2r_pkg::PIX_W-1:0]    out_green,
  input logic [h2r_pkg::PIX_W-1:0]    out_blue
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // An empty output register never blocks a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("request blocked with empty output");

  // A result taken this cycle frees room for a new request
  a_ready_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |-> in_ready)
    else $error("request blocked while result is taken");

  // A stalled result holds its pixel
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue)))
    else $error("stalled result changed");

  // A waiting request holds its pixel
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |=>
      (in_valid && $stable(in_hue) && $stable(in_saturation) && $stable(in_brightness)))
    else $error("waiting request changed");

endmodule

bind hsv_to_rgb_converter h2r_checker u_h2r_checker (.*);

// File: dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the HSV to RGB pixel converter: directed and random pixels.
module tb;
  import h2r_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 80;
  localparam int SETTLE_CYCLES  = 24;
  localparam int PHASE_ITEMS    = 320;
  localparam int HOLD_AT_ITEM   = 100;
  localparam int MAX_REPORTS    = 10;
  localparam int SEXT           = int'(SEXT_UNITS);
  localparam int NUM_PHASES     = 4;
  localparam int SND_IDLE[NUM_PHASES]  = '{0, 76, 0, 35};
  localparam int RCV_STALL[NUM_PHASES] = '{0, 0, 76, 35};

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_pixel_t;

  // Expected pixels in request order, plus the HSV to RGB prediction
  class pixel_scoreboard;
    rgb_pixel_t expected_pixels[$];
    int         mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Exact integer form of the conversion, truncated per channel
    static function rgb_pixel_t convert_pixel(input logic [HUE_W-1:0] hue,
                                              input logic [PIX_W-1:0] sat,
                                              input logic [PIX_W-1:0] bright);
      longint unsigned h, k, r, t, s, v, fs, ch_c, ch_m, ch_x;
      sextant_t        sext;
      rgb_pixel_t      px;
      fs = FULL_SCALE;
      h  = hue;
      h  = h % CIRCLE_UNITS;
      s  = sat;
      v  = bright;
      k  = h / SEXT_UNITS;
      r  = h - k * SEXT_UNITS;
      t  = k[0] ? (SEXT_UNITS - r) : r;
      ch_c = v;
      ch_m = (v * (fs - s)) / fs;
      ch_x = (v * s * t + v * (fs - s) * SEXT_UNITS) / (fs * SEXT_UNITS);
      sext = sextant_t'(k[2:0]);
      case (sext)
        SEXT_RED_YEL: px = '{ch_c[7:0], ch_x[7:0], ch_m[7:0]};
        SEXT_YEL_GRN: px = '{ch_x[7:0], ch_c[7:0], ch_m[7:0]};
        SEXT_GRN_CYN: px = '{ch_m[7:0], ch_c[7:0], ch_x[7:0]};
        SEXT_CYN_BLU: px = '{ch_m[7:0], ch_x[7:0], ch_c[7:0]};
        SEXT_BLU_MAG: px = '{ch_x[7:0], ch_m[7:0], ch_c[7:0]};
        default:      px = '{ch_c[7:0], ch_m[7:0], ch_x[7:0]};
      endcase
      return px;
    endfunction

    function void note_request(input logic [HUE_W-1:0] hue,
                               input logic [PIX_W-1:0] sat,
                               input logic [PIX_W-1:0] bright);
      expected_pixels.push_back(convert_pixel(hue, sat, bright));
    endfunction

    // Compare one delivered pixel with the oldest expectation
    function void check_pixel(input rgb_pixel_t got);
      rgb_pixel_t want;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected pixel r=%0d g=%0d b=%0d with nothing pending",
                   got.red, got.green, got.blue);
        return;
      end
      want = expected_pixels.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("pixel mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                   want.red, want.green, want.blue, got.red, got.green, got.blue);
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic             clk           = 1'b0;
  logic             rst_n         = 1'b0;
  logic             in_valid      = 1'b0;
  logic [HUE_W-1:0] in_hue        = '0;
  logic [PIX_W-1:0] in_saturation = '0;
  logic [PIX_W-1:0] in_brightness = '0;
  logic             out_ready     = 1'b0;
  logic             in_ready;
  logic             out_valid;
  logic [PIX_W-1:0] out_red;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_blue;

  pixel_scoreboard  pixels        = new();
  int               snd_idle_pct  = 0;
  int               rcv_stall_pct = 0;
  bit               hold_req      = 1'b0;
  int               hold_left     = 0;
  int               quiet_cycles  = 0;

  hsv_to_rgb_converter DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  always #CLK_HALF clk = ~clk;

  // Check delivered pixels; drive out_ready with random stalls or a long hold
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      pixels.check_pixel('{out_red, out_green, out_blue});
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request, after an optional idle gap, and hold it until taken
  task automatic send_pixel(input logic [HUE_W-1:0] hue,
                            input logic [PIX_W-1:0] sat,
                            input logic [PIX_W-1:0] bright);
    if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid      <= 1'b1;
    in_hue        <= hue;
    in_saturation <= sat;
    in_brightness <= bright;
    do @(posedge clk); while (!in_ready);
    pixels.note_request(hue, sat, bright);
  endtask

  // Pick a random byte, leaning on the extremes now and then
  function automatic logic [PIX_W-1:0] random_fraction();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  // Random hue: mostly within the circle, some near sextant boundaries or wrapping
  task automatic send_random_pixel();
    int               edge_hue;
    logic [HUE_W-1:0] hue;
    case ($urandom_range(9))
      0: hue = HUE_W'($urandom_range(65535));
      1: begin
        edge_hue = $urandom_range(6) * SEXT + $urandom_range(2) - 1;
        hue = edge_hue[HUE_W-1:0];
      end
      default: hue = HUE_W'($urandom_range(6 * SEXT - 1));
    endcase
    send_pixel(hue, random_fraction(), random_fraction());
  endtask

  // Drop valid and wait until every expected pixel has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pixels.pending() != 0) @(posedge clk);
  endtask

  // Primary and secondary colors at each sextant start, boundaries, wrap, greys and bit patterns
  task automatic run_directed();
    int k;
    for (k = 0; k < 6; k++) send_pixel(HUE_W'(k * SEXT), 8'd255, 8'd255);
    for (k = 0; k < 6; k++) send_pixel(HUE_W'(k * SEXT + SEXT / 2), 8'd200, 8'd180);
    send_pixel(HUE_W'(SEXT - 1), 8'd255, 8'd255);
    send_pixel(HUE_W'(6 * SEXT - 1), 8'd255, 8'd255);
    send_pixel(HUE_W'(6 * SEXT), 8'd255, 8'd255);
    send_pixel(16'hFFFF, 8'd255, 8'd255);
    send_pixel(16'h0000, 8'd0, 8'd0);
    send_pixel(16'd12345, 8'd0, 8'd255);
    send_pixel(16'd12345, 8'd255, 8'd0);
    send_pixel(16'd30000, 8'd1, 8'd254);
    send_pixel(HUE_W'(5 * SEXT + 100), 8'd128, 8'd128);
    send_pixel(16'hAAAA, 8'h55, 8'hAA);
    send_pixel(16'h5555, 8'hAA, 8'h55);
  endtask

  initial begin
    int ph;
    int i;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    drain_results();
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      snd_idle_pct  = SND_IDLE[ph];
      rcv_stall_pct = RCV_STALL[ph];
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // stall the output long enough to back up the whole pipeline
        if (i == HOLD_AT_ITEM && (ph == 0 || ph == NUM_PHASES - 1)) hold_req = 1'b1;
        send_random_pixel();
      end
      drain_results();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pixels.mismatches == 0 && pixels.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: hsv_to_rgb_converter.f
rtl/h2r_pkg.sv
rtl/h2r_front.sv
rtl/h2r_mix.sv
rtl/h2r_scale.sv
rtl/hsv_to_rgb_converter.sv
rtl/h2r_checker.sv
dv/tb.sv
